/* rtl/rsi_pkg.sv */
`timescale 1ns / 1ps
// Shared types, field widths and register codes for the ray/sphere intersection block.
// Every other file in rtl/ depends on this package.

package rsi_pkg;

    localparam int FRAC_BITS_DEF = 16;

    localparam int COORD_W = 32;
    localparam int DIR_W   = 18;
    localparam int RAD_W   = 31;
    localparam int DIST_W  = 31;
    localparam int OP_W    = COORD_W + 1;
    localparam int ADDR_W  = 4;
    localparam int DATA_W  = 32;

    localparam logic [RAD_W-1:0]  RADIUS_RESET = RAD_W'(65536);
    localparam logic [DIST_W-1:0] DIST_MAX     = '1;

    typedef enum logic [1:0] {
        REG_CENTER_X = 2'd0,
        REG_CENTER_Y = 2'd1,
        REG_CENTER_Z = 2'd2,
        REG_RADIUS   = 2'd3
    } t_reg_idx;

    typedef struct packed {
        logic signed [COORD_W-1:0] center_x;
        logic signed [COORD_W-1:0] center_y;
        logic signed [COORD_W-1:0] center_z;
        logic        [RAD_W-1:0]   radius;
    } t_sphere;

    typedef struct packed {
        logic mode;
        logic in_ball;
        logic det_neg;
    } t_flags;

    // Width of b = floor(sum(op*dir) / 2^f), signed.
    function automatic int b_width(input int f);
        return OP_W + DIR_W + 2 - f;
    endfunction

    // Width of the square root of the discriminant.
    function automatic int root_width(input int f);
        return ((b_width(f) > RAD_W) ? b_width(f) : RAD_W) + 1;
    endfunction

endpackage

/* rtl/rsi_cfg.sv */
`timescale 1ns / 1ps
// APB-style register file holding the sphere center and radius.
// Depends on rsi_pkg.

module rsi_cfg (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [rsi_pkg::ADDR_W-1:0]  paddr,
    input  logic [rsi_pkg::DATA_W-1:0]  pwdata,
    output logic [rsi_pkg::DATA_W-1:0]  prdata,
    output logic                        pready,
    output rsi_pkg::t_sphere            o_sphere
);

    rsi_pkg::t_sphere r_sph;
    rsi_pkg::t_reg_idx w_idx;

    assign w_idx  = rsi_pkg::t_reg_idx'(paddr[3:2]);
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sph.center_x <= '0;
            r_sph.center_y <= '0;
            r_sph.center_z <= '0;
            r_sph.radius   <= rsi_pkg::RADIUS_RESET;
        end else if (psel && penable && pwrite) begin
            unique case (w_idx)
                rsi_pkg::REG_CENTER_X: r_sph.center_x <= pwdata;
                rsi_pkg::REG_CENTER_Y: r_sph.center_y <= pwdata;
                rsi_pkg::REG_CENTER_Z: r_sph.center_z <= pwdata;
                rsi_pkg::REG_RADIUS:   r_sph.radius   <= pwdata[rsi_pkg::RAD_W-1:0];
                default:               r_sph.radius   <= r_sph.radius;
            endcase
        end
    end

    always_comb begin
        unique case (w_idx)
            rsi_pkg::REG_CENTER_X: prdata = r_sph.center_x;
            rsi_pkg::REG_CENTER_Y: prdata = r_sph.center_y;
            rsi_pkg::REG_CENTER_Z: prdata = r_sph.center_z;
            rsi_pkg::REG_RADIUS:   prdata = {1'b0, r_sph.radius};
            default:               prdata = '0;
        endcase
    end

    assign o_sphere = r_sph;

endmodule

/* rtl/rsi_front.sv */
`timescale 1ns / 1ps
// Seven-stage front end: center offset, dot product, squared lengths and the discriminant.
// Depends on rsi_pkg.

module rsi_front #(
    parameter int FRAC_BITS = rsi_pkg::FRAC_BITS_DEF
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  rsi_pkg::t_sphere                       i_sphere,
    input  logic                                   i_valid,
    output logic                                   o_ready,
    input  logic                                   i_mode,
    input  logic signed [rsi_pkg::COORD_W-1:0]     i_origin_x,
    input  logic signed [rsi_pkg::COORD_W-1:0]     i_origin_y,
    input  logic signed [rsi_pkg::COORD_W-1:0]     i_origin_z,
    input  logic signed [rsi_pkg::DIR_W-1:0]       i_dir_x,
    input  logic signed [rsi_pkg::DIR_W-1:0]       i_dir_y,
    input  logic signed [rsi_pkg::DIR_W-1:0]       i_dir_z,
    output logic                                   o_valid,
    input  logic                                   i_ready,
    output logic signed [rsi_pkg::b_width(FRAC_BITS)-1:0]    o_b,
    output logic [2*rsi_pkg::root_width(FRAC_BITS)-1:0]      o_det,
    output rsi_pkg::t_flags                        o_flags
);

    localparam int NS     = 7;
    localparam int OP_W   = rsi_pkg::OP_W;
    localparam int DIR_W  = rsi_pkg::DIR_W;
    localparam int PW     = OP_W + DIR_W;
    localparam int B2W    = PW + 2;
    localparam int BW     = rsi_pkg::b_width(FRAC_BITS);
    localparam int SW     = rsi_pkg::root_width(FRAC_BITS);
    localparam int DETU_W = 2 * SW;
    localparam int SQ_W   = 2 * OP_W;
    localparam int OPSQ_W = SQ_W + 2;
    localparam int RSQ_W  = 2 * rsi_pkg::RAD_W;
    localparam int BSQ_W  = 2 * BW;
    localparam int DET_W  = ((BSQ_W > OPSQ_W) ? BSQ_W : OPSQ_W) + 2;
    localparam int L1     = OP_W / 2;
    localparam int H1     = OP_W - L1;
    localparam int L2     = BW / 2;
    localparam int H2     = BW - L2;

    logic [NS-1:0] r_v;
    logic [NS:0]   w_rdy;
    logic [NS-1:0] w_vin;

    logic signed [rsi_pkg::COORD_W-1:0] w_cen [3];
    logic signed [rsi_pkg::COORD_W-1:0] w_org [3];
    logic signed [DIR_W-1:0]            w_dir [3];

    // Stage 1
    logic signed [OP_W-1:0]  r_op  [3];
    logic signed [DIR_W-1:0] r_dir [3];
    logic                    r_mode1;
    // Stage 2
    logic signed [PW-1:0]    r_prod [3];
    logic [2*H1-1:0]         r_ohh  [3];
    logic [H1+L1-1:0]        r_ohl  [3];
    logic [2*L1-1:0]         r_oll  [3];
    logic                    r_mode2;
    logic [OP_W-1:0]         w_opm  [3];
    // Stage 3
    logic [SQ_W-1:0]         r_sq [3];
    logic signed [B2W-1:0]   r_b2;
    logic                    r_mode3;
    // Stage 4
    logic [OPSQ_W-1:0]       r_opsq;
    logic signed [BW-1:0]    r_b4;
    logic [BW-1:0]           r_bm4;
    logic                    r_mode4;
    logic signed [B2W-1:0]   w_bsh;
    logic signed [BW-1:0]    w_b;
    logic [BW-1:0]           w_bm;
    // Stage 5
    logic [2*H2-1:0]         r_bhh;
    logic [H2+L2-1:0]        r_bhl;
    logic [2*L2-1:0]         r_bll;
    logic signed [DET_W-1:0] r_c5;
    logic signed [BW-1:0]    r_b5;
    rsi_pkg::t_flags         r_fl5;
    // Stage 6
    logic [BSQ_W-1:0]        r_bsq;
    logic signed [DET_W-1:0] r_c6;
    logic signed [BW-1:0]    r_b6;
    rsi_pkg::t_flags         r_fl6;
    // Stage 7
    logic [DETU_W-1:0]       r_det;
    logic signed [BW-1:0]    r_b7;
    rsi_pkg::t_flags         r_fl7;
    logic signed [DET_W-1:0] w_det;

    // Radius squared follows the register continuously; it is stable while items fly.
    logic [RSQ_W-1:0]        r_rsq;

    assign w_cen = '{i_sphere.center_x, i_sphere.center_y, i_sphere.center_z};
    assign w_org = '{i_origin_x, i_origin_y, i_origin_z};
    assign w_dir = '{i_dir_x, i_dir_y, i_dir_z};

    // A stage takes new data when it is empty or its contents move on.
    assign w_rdy[NS] = i_ready;
    assign w_vin     = {r_v[NS-2:0], i_valid};
    for (genvar k = 0; k < NS; k++) begin : g_rdy
        assign w_rdy[k] = !r_v[k] || w_rdy[k+1];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            for (int k = 0; k < NS; k++) begin
                if (w_rdy[k]) begin
                    r_v[k] <= w_vin[k];
                end
            end
        end
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_opm[i] = r_op[i][OP_W-1] ? OP_W'(-r_op[i]) : OP_W'(r_op[i]);
        end
    end

    assign w_bsh = r_b2 >>> FRAC_BITS;
    assign w_b   = w_bsh[BW-1:0];
    assign w_bm  = w_b[BW-1] ? BW'(-w_b) : BW'(w_b);
    assign w_det = $signed(DET_W'(r_bsq)) + r_c6;

    always_ff @(posedge i_clk) begin
        r_rsq <= i_sphere.radius * i_sphere.radius;

        if (w_rdy[0]) begin
            for (int i = 0; i < 3; i++) begin
                r_op[i]  <= OP_W'(w_cen[i]) - OP_W'(w_org[i]);
                r_dir[i] <= w_dir[i];
            end
            r_mode1 <= i_mode;
        end

        if (w_rdy[1]) begin
            for (int i = 0; i < 3; i++) begin
                r_prod[i] <= r_op[i] * r_dir[i];
                r_ohh[i]  <= w_opm[i][OP_W-1:L1] * w_opm[i][OP_W-1:L1];
                r_ohl[i]  <= w_opm[i][OP_W-1:L1] * w_opm[i][L1-1:0];
                r_oll[i]  <= w_opm[i][L1-1:0] * w_opm[i][L1-1:0];
            end
            r_mode2 <= r_mode1;
        end

        if (w_rdy[2]) begin
            for (int i = 0; i < 3; i++) begin
                r_sq[i] <= (SQ_W'(r_ohh[i]) << (2 * L1)) + (SQ_W'(r_ohl[i]) << (L1 + 1))
                           + SQ_W'(r_oll[i]);
            end
            r_b2    <= B2W'(r_prod[0]) + B2W'(r_prod[1]) + B2W'(r_prod[2]);
            r_mode3 <= r_mode2;
        end

        if (w_rdy[3]) begin
            r_opsq  <= OPSQ_W'(r_sq[0]) + OPSQ_W'(r_sq[1]) + OPSQ_W'(r_sq[2]);
            r_b4    <= w_b;
            r_bm4   <= w_bm;
            r_mode4 <= r_mode3;
        end

        if (w_rdy[4]) begin
            r_bhh          <= r_bm4[BW-1:L2] * r_bm4[BW-1:L2];
            r_bhl          <= r_bm4[BW-1:L2] * r_bm4[L2-1:0];
            r_bll          <= r_bm4[L2-1:0] * r_bm4[L2-1:0];
            r_c5           <= $signed(DET_W'(r_rsq)) - $signed(DET_W'(r_opsq));
            r_b5           <= r_b4;
            r_fl5.mode     <= r_mode4;
            r_fl5.in_ball  <= r_opsq <= OPSQ_W'(r_rsq);
            r_fl5.det_neg  <= 1'b0;
        end

        if (w_rdy[5]) begin
            r_bsq <= (BSQ_W'(r_bhh) << (2 * L2)) + (BSQ_W'(r_bhl) << (L2 + 1))
                     + BSQ_W'(r_bll);
            r_c6  <= r_c5;
            r_b6  <= r_b5;
            r_fl6 <= r_fl5;
        end

        if (w_rdy[6]) begin
            r_det         <= w_det[DETU_W-1:0];
            r_b7          <= r_b6;
            r_fl7.mode    <= r_fl6.mode;
            r_fl7.in_ball <= r_fl6.in_ball;
            r_fl7.det_neg <= w_det[DET_W-1];
        end
    end

    assign o_ready = w_rdy[0];
    assign o_valid = r_v[NS-1];
    assign o_b     = r_b7;
    assign o_det   = r_det;
    assign o_flags = r_fl7;

endmodule

/* rtl/rsi_sqrt.sv */
`timescale 1ns / 1ps
// Pipelined integer square root, one result bit per stage, with sideband carried along.
// Depends on rsi_pkg.

module rsi_sqrt #(
    parameter int FRAC_BITS = rsi_pkg::FRAC_BITS_DEF
) (
    input  logic                                              i_clk,
    input  logic                                              i_rst_n,
    input  logic                                              i_valid,
    output logic                                              o_ready,
    input  logic signed [rsi_pkg::b_width(FRAC_BITS)-1:0]     i_b,
    input  logic [2*rsi_pkg::root_width(FRAC_BITS)-1:0]       i_det,
    input  rsi_pkg::t_flags                                   i_flags,
    output logic                                              o_valid,
    input  logic                                              i_ready,
    output logic signed [rsi_pkg::b_width(FRAC_BITS)-1:0]     o_b,
    output logic [rsi_pkg::root_width(FRAC_BITS)-1:0]         o_root,
    output rsi_pkg::t_flags                                   o_flags
);

    localparam int BW     = rsi_pkg::b_width(FRAC_BITS);
    localparam int SW     = rsi_pkg::root_width(FRAC_BITS);
    localparam int DETU_W = 2 * SW;

    logic [SW-1:0]        r_v;
    logic [SW:0]          w_rdy;
    logic [SW-1:0]        w_vin;

    logic [DETU_W-1:0]    r_rem  [SW];
    logic [SW-1:0]        r_root [SW];
    logic signed [BW-1:0] r_b    [SW];
    rsi_pkg::t_flags      r_fl   [SW];

    assign w_rdy[SW] = i_ready;
    assign w_vin     = {r_v[SW-2:0], i_valid};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            for (int k = 0; k < SW; k++) begin
                if (w_rdy[k]) begin
                    r_v[k] <= w_vin[k];
                end
            end
        end
    end

    for (genvar j = 0; j < SW; j++) begin : g_stage
        localparam int K = SW - 1 - j;

        logic [DETU_W-1:0]    w_rem_in;
        logic [SW-1:0]        w_root_in;
        logic signed [BW-1:0] w_b_in;
        rsi_pkg::t_flags      w_fl_in;
        logic [DETU_W-1:0]    w_trial;
        logic                 w_take;

        assign w_rdy[j] = !r_v[j] || w_rdy[j+1];

        if (j == 0) begin : g_first
            assign w_rem_in  = i_det;
            assign w_root_in = '0;
            assign w_b_in    = i_b;
            assign w_fl_in   = i_flags;
        end else begin : g_next
            assign w_rem_in  = r_rem[j-1];
            assign w_root_in = r_root[j-1];
            assign w_b_in    = r_b[j-1];
            assign w_fl_in   = r_fl[j-1];
        end

        // Setting bit K grows the square by (2*root + 2^K) * 2^K.
        assign w_trial = (DETU_W'(w_root_in) << (K + 1)) | (DETU_W'(1) << (2 * K));
        assign w_take  = w_trial <= w_rem_in;

        always_ff @(posedge i_clk) begin
            if (w_rdy[j]) begin
                r_rem[j]  <= w_take ? (w_rem_in - w_trial) : w_rem_in;
                r_root[j] <= w_take ? (w_root_in | (SW'(1) << K)) : w_root_in;
                r_b[j]    <= w_b_in;
                r_fl[j]   <= w_fl_in;
            end
        end
    end

    assign o_ready = w_rdy[0];
    assign o_valid = r_v[SW-1];
    assign o_b     = r_b[SW-1];
    assign o_root  = r_root[SW-1];
    assign o_flags = r_fl[SW-1];

endmodule

/* rtl/rsi_back.sv */
`timescale 1ns / 1ps
// Root selection against eps, saturation and the output register.
// Depends on rsi_pkg.

module rsi_back #(
    parameter int FRAC_BITS = rsi_pkg::FRAC_BITS_DEF
) (
    input  logic                                              i_clk,
    input  logic                                              i_rst_n,
    input  logic                                              i_valid,
    output logic                                              o_ready,
    input  logic signed [rsi_pkg::b_width(FRAC_BITS)-1:0]     i_b,
    input  logic [rsi_pkg::root_width(FRAC_BITS)-1:0]         i_root,
    input  rsi_pkg::t_flags                                   i_flags,
    output logic                                              o_valid,
    input  logic                                              i_ready,
    output logic                                              o_hit,
    output logic [rsi_pkg::DIST_W-1:0]                        o_distance,
    output logic                                              o_inside_res
);

    localparam int BW  = rsi_pkg::b_width(FRAC_BITS);
    localparam int SW  = rsi_pkg::root_width(FRAC_BITS);
    localparam int TW  = ((BW > SW) ? BW : SW) + 2;
    localparam int EPS = ((1 << FRAC_BITS) + 5000) / 10000;
    localparam logic signed [TW-1:0] T_EPS  = TW'(EPS);
    localparam logic signed [TW-1:0] T_DMAX = TW'($signed({1'b0, rsi_pkg::DIST_MAX}));

    logic [1:0]           r_v;
    logic [2:0]           w_rdy;

    logic signed [TW-1:0] r_t1;
    logic signed [TW-1:0] r_t2;
    rsi_pkg::t_flags      r_fl;

    logic                      r_hit;
    logic [rsi_pkg::DIST_W-1:0] r_dist;
    logic                      r_inside;

    logic                 w_ray;
    logic                 w_hit;
    logic signed [TW-1:0] w_t;
    logic [rsi_pkg::DIST_W-1:0] w_dist;

    assign w_rdy[2] = i_ready;
    assign w_rdy[1] = !r_v[1] || w_rdy[2];
    assign w_rdy[0] = !r_v[0] || w_rdy[1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (w_rdy[0]) begin
                r_v[0] <= i_valid;
            end
            if (w_rdy[1]) begin
                r_v[1] <= r_v[0];
            end
        end
    end

    always_comb begin
        w_ray = !r_fl.mode && !r_fl.det_neg;
        w_hit = 1'b0;
        w_t   = '0;
        priority if (w_ray && (r_t1 > T_EPS)) begin
            w_hit = 1'b1;
            w_t   = r_t1;
        end else if (w_ray && (r_t2 > T_EPS)) begin
            w_hit = 1'b1;
            w_t   = r_t2;
        end else begin
            w_hit = 1'b0;
            w_t   = '0;
        end
        w_dist = (w_t > T_DMAX) ? rsi_pkg::DIST_MAX : w_t[rsi_pkg::DIST_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy[0]) begin
            r_t1 <= TW'(i_b) - TW'($signed({1'b0, i_root}));
            r_t2 <= TW'(i_b) + TW'($signed({1'b0, i_root}));
            r_fl <= i_flags;
        end
        if (w_rdy[1]) begin
            r_hit    <= w_hit;
            r_dist   <= w_dist;
            r_inside <= r_fl.mode && r_fl.in_ball;
        end
    end

    assign o_ready      = w_rdy[0];
    assign o_valid      = r_v[1];
    assign o_hit        = r_hit;
    assign o_distance   = r_dist;
    assign o_inside_res = r_inside;

endmodule

/* rtl/ray_sphere_intersection.sv */
`timescale 1ns / 1ps
// Top level of the ray/sphere intersection block: register file and the three pipeline parts.
// Depends on rsi_pkg, rsi_cfg, rsi_front, rsi_sqrt and rsi_back.

// This block tests one ray per word against a single sphere held in registers (center at
// byte addresses 0, 4 and 8, radius at 12, all Q16.16 by default), or in point mode tells
// whether the point lies within the radius. It is a fully pipelined design that accepts a new
// word every clock cycle unless a stalled output has filled the pipeline, and returns exactly
// one result word per input word, in order. The square root is root_width bits wide, where
// root_width = max(53 - FRAC_BITS, 31) + 1. Seven front stages form the center offset, the dot
// product with the direction, the squared lengths and the discriminant; the square root then
// resolves one bit per stage, which sets most of the latency; two final stages pick the nearer
// root beyond eps (7 LSB at Q16.16), saturate the distance and hold the output register.
// Every stage carries its own valid bit and fills whenever it is empty, so a stalled output
// never blocks the input until the whole pipeline is full. A negative discriminant, or no root
// beyond eps, gives hit 0 and distance 0. The direction is used as given, without
// normalization. Registers must only be written while no word is in flight.

module ray_sphere_intersection #(
    parameter int FRAC_BITS = rsi_pkg::FRAC_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [rsi_pkg::ADDR_W-1:0]          paddr,
    input  logic [rsi_pkg::DATA_W-1:0]          pwdata,
    output logic [rsi_pkg::DATA_W-1:0]          prdata,
    output logic                                pready,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic                                i_mode,
    input  logic signed [rsi_pkg::COORD_W-1:0]  i_origin_x,
    input  logic signed [rsi_pkg::COORD_W-1:0]  i_origin_y,
    input  logic signed [rsi_pkg::COORD_W-1:0]  i_origin_z,
    input  logic signed [rsi_pkg::DIR_W-1:0]    i_dir_x,
    input  logic signed [rsi_pkg::DIR_W-1:0]    i_dir_y,
    input  logic signed [rsi_pkg::DIR_W-1:0]    i_dir_z,
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic                                o_hit,
    output logic [rsi_pkg::DIST_W-1:0]          o_distance,
    output logic                                o_inside_res
);

    localparam int BW      = rsi_pkg::b_width(FRAC_BITS);
    localparam int SW      = rsi_pkg::root_width(FRAC_BITS);
    localparam int EPS_LSB = ((1 << FRAC_BITS) + 5000) / 10000;

    rsi_pkg::t_sphere      w_sphere;

    // Front end to square root.
    logic                  w_f_valid;
    logic                  w_f_ready;
    logic signed [BW-1:0]  w_f_b;
    logic [2*SW-1:0]       w_f_det;
    rsi_pkg::t_flags       w_f_flags;

    // Square root to back end.
    logic                  w_s_valid;
    logic                  w_s_ready;
    logic signed [BW-1:0]  w_s_b;
    logic [SW-1:0]         w_s_root;
    rsi_pkg::t_flags       w_s_flags;

    rsi_cfg u_cfg (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .o_sphere (w_sphere)
    );

    rsi_front #(
        .FRAC_BITS (FRAC_BITS)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_sphere   (w_sphere),
        .i_valid    (i_valid),
        .o_ready    (o_ready),
        .i_mode     (i_mode),
        .i_origin_x (i_origin_x),
        .i_origin_y (i_origin_y),
        .i_origin_z (i_origin_z),
        .i_dir_x    (i_dir_x),
        .i_dir_y    (i_dir_y),
        .i_dir_z    (i_dir_z),
        .o_valid    (w_f_valid),
        .i_ready    (w_f_ready),
        .o_b        (w_f_b),
        .o_det      (w_f_det),
        .o_flags    (w_f_flags)
    );

    rsi_sqrt #(
        .FRAC_BITS (FRAC_BITS)
    ) u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_f_valid),
        .o_ready (w_f_ready),
        .i_b     (w_f_b),
        .i_det   (w_f_det),
        .i_flags (w_f_flags),
        .o_valid (w_s_valid),
        .i_ready (w_s_ready),
        .o_b     (w_s_b),
        .o_root  (w_s_root),
        .o_flags (w_s_flags)
    );

    rsi_back #(
        .FRAC_BITS (FRAC_BITS)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (w_s_valid),
        .o_ready      (w_s_ready),
        .i_b          (w_s_b),
        .i_root       (w_s_root),
        .i_flags      (w_s_flags),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_hit        (o_hit),
        .o_distance   (o_distance),
        .o_inside_res (o_inside_res)
    );

`ifndef SYNTHESIS
    // A reported hit always lies beyond eps.
    a_hit_beyond_eps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_hit |-> o_distance > rsi_pkg::DIST_W'(EPS_LSB))
        else $error("hit reported at or below eps");

    // A miss carries a zero distance.
    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_hit |-> o_distance == '0)
        else $error("miss with nonzero distance");

    // Point mode and ray hits never show together.
    a_modes_apart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_inside_res |-> !o_hit)
        else $error("inside and hit both set");

    // The input only stalls when a finished result is held back at the output.
    a_stall_only_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_ready |-> o_valid && !i_ready)
        else $error("input stalled while output is free");
`endif

endmodule

/* tb/sv/tb.sv */
`timescale 1ns / 1ps
// Self-checking testbench for ray_sphere_intersection: random and directed rays and points.
// Depends on rsi_pkg and the ray_sphere_intersection RTL; needs nothing else.

module tb;
    import rsi_pkg::*;

    localparam int LATENCY     = 47;
    localparam int DRAIN_WAIT  = LATENCY + 20;
    localparam int CYCLE_LIMIT = 600000;
    localparam int ONE         = 65536;
    localparam longint EPS     = 7;

    typedef logic signed [127:0] wide_t;

    // One ray or point as offered to the block.
    typedef struct {
        logic                      mode;
        logic signed [COORD_W-1:0] ox, oy, oz;
        logic signed [DIR_W-1:0]   dx, dy, dz;
    } ray_t;

    // One result word.
    typedef struct {
        logic              hit;
        logic [DIST_W-1:0] dlen;
        logic              in_pt;
    } hit_t;

    // Predicts the result of every accepted word and compares the block's results in order.
    class SphereScoreboard;
        logic signed [COORD_W-1:0] cx, cy, cz;
        logic [RAD_W-1:0]          radius;
        hit_t                      pending[$];
        int                        fails;

        function void reset_regs();
            cx = 0;
            cy = 0;
            cz = 0;
            radius = RADIUS_RESET;
            fails = 0;
        endfunction

        function void set_reg(t_reg_idx idx, logic [31:0] val);
            case (idx)
                REG_CENTER_X: cx = val;
                REG_CENTER_Y: cy = val;
                REG_CENTER_Z: cz = val;
                REG_RADIUS:   radius = val[RAD_W-1:0];
            endcase
        endfunction

        // Floor of the square root of a non-negative value below 2^96.
        function logic [47:0] floor_root(wide_t v);
            logic [47:0] s;
            logic [47:0] t;
            wide_t       tt;
            s = '0;
            for (int k = 47; k >= 0; k--) begin
                t = s | (48'd1 << k);
                tt = {80'd0, t};
                if (tt * tt <= v)
                    s = t;
            end
            return s;
        endfunction

        function void note_ray(ray_t r);
            longint opx, opy, opz, dot, b, t1, t2, dlen;
            wide_t  opsq, rsq, det;
            hit_t   e;
            opx = longint'(cx) - longint'(r.ox);
            opy = longint'(cy) - longint'(r.oy);
            opz = longint'(cz) - longint'(r.oz);
            opsq = wide_t'(opx) * wide_t'(opx) + wide_t'(opy) * wide_t'(opy)
                 + wide_t'(opz) * wide_t'(opz);
            rsq = {97'd0, radius} * {97'd0, radius};
            e = '{hit: 1'b0, dlen: '0, in_pt: 1'b0};
            if (r.mode) begin
                e.in_pt = (opsq <= rsq);
            end else begin
                dot = opx * longint'(r.dx) + opy * longint'(r.dy) + opz * longint'(r.dz);
                // Arithmetic shift floors toward minus infinity.
                b = dot >>> FRAC_BITS_DEF;
                det = wide_t'(b) * wide_t'(b) + rsq - opsq;
                if (det >= 0) begin
                    t1 = b - longint'(floor_root(det));
                    t2 = b + longint'(floor_root(det));
                    dlen = 0;
                    if (t1 > EPS) begin
                        e.hit = 1'b1;
                        dlen = t1;
                    end else if (t2 > EPS) begin
                        e.hit = 1'b1;
                        dlen = t2;
                    end
                    if (dlen > longint'(DIST_MAX))
                        dlen = longint'(DIST_MAX);
                    e.dlen = dlen[DIST_W-1:0];
                end
            end
            pending.push_back(e);
        endfunction

        function void check_word(logic hit, logic [DIST_W-1:0] dlen, logic in_pt);
            hit_t e;
            if (pending.size() == 0) begin
                $error("result word with no prediction waiting");
                fails++;
                return;
            end
            e = pending.pop_front();
            if (hit !== e.hit) begin
                $error("hit: expected %0d, actual %0d", e.hit, hit);
                fails++;
            end
            if (dlen !== e.dlen) begin
                $error("distance: expected %0d, actual %0d", e.dlen, dlen);
                fails++;
            end
            if (in_pt !== e.in_pt) begin
                $error("inside_res: expected %0d, actual %0d", e.in_pt, in_pt);
                fails++;
            end
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [ADDR_W-1:0] paddr = '0;
    logic [DATA_W-1:0] pwdata = '0;
    logic [DATA_W-1:0] prdata;
    logic pready;
    logic i_valid = 1'b0;
    logic o_ready;
    logic i_mode = 1'b0;
    logic signed [COORD_W-1:0] i_origin_x = '0, i_origin_y = '0, i_origin_z = '0;
    logic signed [DIR_W-1:0] i_dir_x = '0, i_dir_y = '0, i_dir_z = '0;
    logic o_valid;
    logic i_ready = 1'b0;
    logic o_hit;
    logic [DIST_W-1:0] o_distance;
    logic o_inside_res;

    SphereScoreboard sb = new();
    int  cycles = 0;
    int  hold_requests = 0;   // bumped by the sender to ask for a long receiver stall
    int  hold_seen = 0;
    int  hold_left = 0;
    bit  steady = 1'b0;       // when set, neither side idles

    ray_sphere_intersection dut (.*);

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // The run is cut off, and reported as a mismatch, once the cycle counter passes CYCLE_LIMIT.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // Mostly short gaps, now and then a long one.
    function automatic int pick_gap();
        int p;
        p = $urandom_range(0, 99);
        if (steady || p < 60)
            return 0;
        if (p < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Receiver: checks each accepted word, then decides the next cycle's ready. A long
    // hold, requested by the sender, lets the pipeline fill so that o_ready drops.
    always @(posedge i_clk) begin
        int g_len;
        if (i_rst_n && o_valid && i_ready)
            sb.check_word(o_hit, o_distance, o_inside_res);
        if (hold_requests != hold_seen) begin
            hold_seen <= hold_requests;
            hold_left <= 300;
            i_ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            i_ready <= 1'b0;
        end else if (i_ready) begin
            g_len = pick_gap();
            if (g_len > 0) begin
                hold_left <= g_len - 1;
                i_ready <= 1'b0;
            end
        end else begin
            i_ready <= 1'b1;
        end
    end

    // A register write has a setup phase and an access phase.
    task automatic write_reg(t_reg_idx idx, logic [31:0] val);
        @(posedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= ADDR_W'(4 * int'(idx));
        pwdata <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready)
            @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        sb.set_reg(idx, val);
    endtask

    // Registers change only once every predicted word has come back and the pipe is empty.
    task automatic load_sphere(logic [31:0] x, logic [31:0] y, logic [31:0] z,
                               logic [31:0] r);
        i_valid <= 1'b0;
        while (sb.pending.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
        write_reg(REG_CENTER_X, x);
        write_reg(REG_CENTER_Y, y);
        write_reg(REG_CENTER_Z, z);
        write_reg(REG_RADIUS, r);
    endtask

    // Offers one word and holds it until the block takes it.
    task automatic send_ray(ray_t r);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_mode <= r.mode;
        i_origin_x <= r.ox;
        i_origin_y <= r.oy;
        i_origin_z <= r.oz;
        i_dir_x <= r.dx;
        i_dir_y <= r.dy;
        i_dir_z <= r.dz;
        @(posedge i_clk);
        while (!o_ready)
            @(posedge i_clk);
        sb.note_ray(r);
    endtask

    function automatic ray_t mk(logic m, longint ox, longint oy, longint oz,
                                longint dx, longint dy, longint dz);
        ray_t r;
        r.mode = m;
        r.ox = ox[31:0];
        r.oy = oy[31:0];
        r.oz = oz[31:0];
        r.dx = dx[17:0];
        r.dy = dy[17:0];
        r.dz = dz[17:0];
        return r;
    endfunction

    function automatic longint clamp32(longint v);
        if (v > 64'sd2147483647)
            return 64'sd2147483647;
        if (v < -64'sd2147483648)
            return -64'sd2147483648;
        return v;
    endfunction

    // Most words are rays aimed near the sphere or points around it; the rest are noise
    // over the whole range of every field, directions of any length included.
    function automatic ray_t random_ray();
        longint d[3], c[3], o[3], span, jit, rr;
        int     kind, ax;
        ray_t   r;
        kind = $urandom_range(0, 9);
        rr = longint'(sb.radius);
        c[0] = sb.cx;
        c[1] = sb.cy;
        c[2] = sb.cz;
        if (kind < 2) begin
            r = mk($urandom_range(0, 1), $signed($urandom), $signed($urandom),
                   $signed($urandom), $urandom, $urandom, $urandom);
            return r;
        end
        d = '{0, 0, 0};
        ax = $urandom_range(0, 2);
        if ($urandom_range(0, 1)) begin
            d[ax] = ONE;
        end else begin
            d[ax] = 46341;
            d[(ax + 1) % 3] = 46341;
        end
        for (int i = 0; i < 3; i++)
            if ($urandom_range(0, 1))
                d[i] = -d[i];
        span = longint'($urandom_range(0, 8)) * rr + longint'($urandom_range(0, 65535));
        for (int i = 0; i < 3; i++) begin
            jit = (rr > 0) ? longint'($urandom_range(0, 32'hFFFF_FFFE)) % (2 * rr + 1) - rr : 0;
            if (kind == 2)
                o[i] = clamp32(c[i] + 2 * jit);
            else
                o[i] = clamp32(c[i] - ((d[i] * span) >>> 16) + jit / 2);
        end
        r = mk(kind == 2, o[0], o[1], o[2], d[0], d[1], d[2]);
        return r;
    endfunction

    task automatic send_random(int n);
        for (int i = 0; i < n; i++) begin
            if (i % 50 == 0)
                steady <= (i % 100 == 50);
            send_ray(random_ray());
        end
        steady <= 1'b0;
    endtask

    initial begin
        sb.reset_regs();
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part against the reset sphere: unit sphere at the origin.
        send_ray(mk(0, -5 * ONE, 0, 0, ONE, 0, 0));           // plain hit, nearer root
        send_ray(mk(0, 0, 0, 0, ONE, 0, 0));                  // origin inside, farther root
        send_ray(mk(0, 5 * ONE, 0, 0, ONE, 0, 0));            // sphere behind the ray
        send_ray(mk(0, -5 * ONE, 2 * ONE, 0, ONE, 0, 0));     // negative discriminant
        send_ray(mk(0, -5 * ONE, ONE, 0, ONE, 0, 0));         // grazing ray
        send_ray(mk(0, ONE - 3, 0, 0, ONE, 0, 0));            // farther root within eps
        send_ray(mk(0, ONE - 20, 0, 0, ONE, 0, 0));           // farther root just past eps
        send_ray(mk(0, 0, 0, -3 * ONE, 0, 0, ONE));
        send_ray(mk(0, 0, 4 * ONE, 0, 0, -ONE, 0));
        send_ray(mk(0, -3 * ONE, 0, 0, 2 * ONE, 0, 0));       // non-unit direction
        send_ray(mk(0, -2147483648, 2147483647, -2147483648,
                    -131072, 131071, 65536));                 // field extremes
        send_ray(mk(0, 2147483647, -2147483648, 2147483647,
                    131071, -131072, -65536));
        send_ray(mk(1, 0, 0, 0, 131071, -131072, 7));         // point at center
        send_ray(mk(1, ONE, 0, 0, 0, 0, 0));                  // point on the surface
        send_ray(mk(1, ONE + 1, 0, 0, 0, 0, 0));              // just outside
        send_ray(mk(1, -2147483648, -2147483648, -2147483648, 0, 0, 0));

        // Offset sphere, with one long receiver stall so the block backs up.
        load_sphere(32'sd229376, -32'sd131072, 32'sd655360, 32'd163840);
        hold_requests <= hold_requests + 1;
        send_random(150);

        // Extreme centers and the largest radius: the distance saturates.
        load_sphere(32'h8000_0000, 32'h7FFF_FFFF, 32'd0, 32'h7FFF_FFFF);
        send_ray(mk(0, 2147483647, 2147483647, 0, -ONE, 0, 0));
        send_ray(mk(0, 2147483647, 2147483647, 0, ONE, 0, 0));
        send_ray(mk(1, 2147483647, 2147483647, 0, 0, 0, 0));
        send_random(60);

        // Zero radius.
        load_sphere(32'd0, 32'd0, 32'd0, 32'd0);
        send_ray(mk(0, -5 * ONE, 0, 0, ONE, 0, 0));
        send_ray(mk(1, 0, 0, 0, 0, 0, 0));
        send_random(40);

        load_sphere($urandom_range(0, 1 << 22) - (1 << 21), $urandom_range(0, 1 << 22) - (1 << 21),
                    $urandom_range(0, 1 << 22) - (1 << 21), $urandom_range(ONE, 16 * ONE));
        send_random(150);

        load_sphere($urandom, $urandom, $urandom, $urandom_range(0, 32'h7FFF_FFFF));
        send_random(100);
        i_valid <= 1'b0;

        while (sb.pending.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (sb.fails == 0 && sb.pending.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

/* sim.f */
rtl/rsi_pkg.sv
rtl/rsi_cfg.sv
rtl/rsi_front.sv
rtl/rsi_sqrt.sv
rtl/rsi_back.sv
rtl/ray_sphere_intersection.sv
tb/sv/tb.sv
